[rtl/tivf_pkg.sv]
// shared types and constants for the track identity vote fuser
package tivf_pkg;
   localparam int MAX_TRACKS_DEF     = 16;
   localparam int NUM_IDENTITIES_DEF = 20;
   localparam int NUM_CANDIDATES_DEF = 3;
   localparam int KEY_W   = 64;
   localparam int CID_W   = 5;
   localparam int CONF_W  = 10;
   localparam int SCORE_W = 24;
   localparam int CNT_W   = 8;
   localparam int THR_W   = 7;
   localparam int TNUM_W  = 5;
   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
   localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
   localparam logic [THR_W-1:0]   THR_RESET = 7'd18;
   localparam logic [CNT_W-1:0]   MINUPD_RESET = 8'd5;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MINUPD = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SEARCH, ST_SLOT, ST_CAND_RD, ST_CAND_WR,
      ST_SCAN_RD, ST_SCAN, ST_CONF_RD, ST_DECIDE, ST_OUT
   } state_type;
endpackage

[rtl/tivf_ram.sv]
// generic single-port-write ram with registered read
module tivf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[rtl/track_identity_vote_fuser.sv]
// top level of the track identity vote fuser
// latency from the accepting edge to rsp_valid is set by the key search over the used slots,
//   the candidate updates and the scan of the score ram over all identities
// throughput: one observation at a time; the result register frees the input, a still stalled
//   result holds the output state
// reset: synchronous, clears control state, then a clearing pass over all MAX_TRACKS*NUM_IDENTITIES
//   entries zeroes the score and confirmed rams while no observation is taken
module track_identity_vote_fuser
   import tivf_pkg::*;
#(
   parameter int MAX_TRACKS     = MAX_TRACKS_DEF,
   parameter int NUM_IDENTITIES = NUM_IDENTITIES_DEF,
   parameter int NUM_CANDIDATES = NUM_CANDIDATES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tivf_pkg::KEY_W-1:0]  req_body_track_id,
   input  logic                        req_face_found,
   input  logic [tivf_pkg::CID_W-1:0]  req_cand0_id,
   input  logic [tivf_pkg::CONF_W-1:0] req_cand0_conf,
   input  logic [tivf_pkg::CID_W-1:0]  req_cand1_id,
   input  logic [tivf_pkg::CONF_W-1:0] req_cand1_conf,
   input  logic [tivf_pkg::CID_W-1:0]  req_cand2_id,
   input  logic [tivf_pkg::CONF_W-1:0] req_cand2_conf,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tivf_pkg::KEY_W-1:0]  rsp_echo_track_id,
   output logic [tivf_pkg::TNUM_W-1:0] rsp_track_number,
   output logic [tivf_pkg::CID_W-1:0]  rsp_best_id,
   output logic [tivf_pkg::SCORE_W-1:0] rsp_best_score,
   output logic [tivf_pkg::SCORE_W-1:0] rsp_second_score,
   output logic [tivf_pkg::CID_W-1:0]  rsp_decided_id,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [7:0]                  csr_index,
   input  logic [7:0]                  csr_data
);
   localparam int SW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int UW  = $clog2(MAX_TRACKS + 1);
   localparam int IW  = (NUM_IDENTITIES > 1) ? $clog2(NUM_IDENTITIES) : 1;
   localparam int IDW = $clog2(NUM_IDENTITIES + 1);
   localparam int VD  = MAX_TRACKS * NUM_IDENTITIES;
   localparam int VW  = $clog2(VD);
   localparam int CW  = $clog2(NUM_CANDIDATES + 1);
   localparam int PW  = SCORE_W + THR_W;

   // configuration registers
   logic [THR_W-1:0] thr_ff;
   logic [CNT_W-1:0] minupd_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THR_RESET;
         minupd_ff <= MINUPD_RESET;
      end else if (csr_valid) begin
         if (csr_index == 8'(CSR_RATIO))  thr_ff <= csr_data[THR_W-1:0];
         if (csr_index == 8'(CSR_MINUPD)) minupd_ff <= csr_data;
      end
   end

   // control and payload registers
   state_type state_ff, state_in;
   logic [KEY_W-1:0] key_ff;
   logic face_ff;
   logic [CID_W-1:0] cid_ff [4];
   logic [CONF_W-1:0] conf_ff [4];
   logic [UW-1:0] used_ff, used_in;
   logic [UW-1:0] idx_ff, idx_in;      // search index
   logic [SW-1:0] slot_ff, slot_in;
   logic [IDW-1:0] sid_ff, sid_in;     // scan identity counter
   logic [VW:0] clr_ff, clr_in;
   logic [SCORE_W-1:0] best_ff, best_in, sec_ff, sec_in;
   logic [IW-1:0] bid_ff, bid_in;
   logic [CW-1:0] cnum_ff, cnum_in;
   logic [CNT_W-1:0] ucnt_ff, ucnt_in;
   logic conf_hit_ff, conf_hit_in;
   logic rv_ff;
   logic [TNUM_W-1:0] tn_ff;
   logic [CID_W-1:0] ob_ff, od_ff;
   logic [SCORE_W-1:0] obs_ff, oss_ff;
   logic [KEY_W-1:0] oe_ff;

   // memories
   logic key_we; logic [SW-1:0] key_wa, key_ra; logic [KEY_W-1:0] key_rd;
   logic vs_we; logic [VW-1:0] vs_wa, vs_ra; logic [SCORE_W-1:0] vs_wd, vs_rd;
   logic cm_we; logic [VW-1:0] cm_wa; logic cm_wd, cm_rd;
   logic uc_we; logic [CNT_W-1:0] uc_wd, uc_rd;
   logic [MAX_TRACKS-1:0] uc_valid_ff;

   tivf_ram #(.WIDTH(KEY_W), .DEPTH(MAX_TRACKS)) u_keys (
      .clock, .wr_en(key_we), .wr_addr(key_wa), .wr_data(key_ff),
      .rd_addr(key_ra), .rd_data(key_rd));
   tivf_ram #(.WIDTH(SCORE_W), .DEPTH(VD)) u_scores (
      .clock, .wr_en(vs_we), .wr_addr(vs_wa), .wr_data(vs_wd),
      .rd_addr(vs_ra), .rd_data(vs_rd));
   tivf_ram #(.WIDTH(1), .DEPTH(VD)) u_marks (
      .clock, .wr_en(cm_we), .wr_addr(cm_wa), .wr_data(cm_wd),
      .rd_addr(vs_ra), .rd_data(cm_rd));
   // read follows the slot being chosen so the count is ready right after the search
   tivf_ram #(.WIDTH(CNT_W), .DEPTH(MAX_TRACKS)) u_counts (
      .clock, .wr_en(uc_we), .wr_addr(slot_ff), .wr_data(uc_wd),
      .rd_addr(slot_in), .rd_data(uc_rd));

   // entry address of slot and identity
   function automatic logic [VW-1:0] vaddr(input logic [SW-1:0] s, input logic [IW-1:0] i);
      logic [VW+SW:0] a;
      a = (VW+SW+1)'(s) * (VW+SW+1)'(NUM_IDENTITIES) + (VW+SW+1)'(i);
      return a[VW-1:0];
   endfunction

   logic [IW-1:0] cur_cid;
   logic cid_ok;
   logic [CW-1:0] cn_sel;
   logic [SCORE_W:0] ssum;
   logic [PW-1:0] lhs, rhs;
   logic confirm, ucnt_valid_rd;
   logic out_load;

   // result register loads once the previous result has gone
   assign out_load = (state_ff == ST_OUT) && !(rv_ff && rsp_stall);

   always_comb begin
      cn_sel  = cnum_ff;
      cur_cid = cid_ff[cn_sel[1:0]][IW-1:0];
      cid_ok  = (32'(cid_ff[cn_sel[1:0]]) < 32'(NUM_IDENTITIES));
      ssum    = (SCORE_W+1)'(vs_rd) + (SCORE_W+1)'(conf_ff[cn_sel[1:0]]);
      lhs     = PW'(best_ff) * PW'(10);
      rhs     = PW'(thr_ff) * PW'(sec_ff);
      confirm = (best_ff != '0) && ((sec_ff == '0) || (lhs >= rhs));
      ucnt_valid_rd = uc_valid_ff[slot_ff];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   if (clr_ff == (VW+1)'(VD - 1)) state_in = ST_IDLE;
         ST_IDLE:    if (req_valid && req_body_track_id != '0) state_in = ST_SEARCH;
         ST_SEARCH:  state_in = ST_SLOT;
         ST_SLOT: begin
            if (idx_ff != '0 && key_rd == key_ff) state_in = ST_CAND_RD;
            else if (idx_ff < used_ff) state_in = ST_SLOT;
            else if (!face_ff || used_ff >= UW'(MAX_TRACKS)) state_in = ST_IDLE;
            else state_in = ST_CAND_RD;
         end
         ST_CAND_RD: state_in = (face_ff && cnum_ff < CW'(NUM_CANDIDATES)) ? ST_CAND_WR
                                                                               : ST_SCAN_RD;
         ST_CAND_WR: state_in = ST_CAND_RD;
         ST_SCAN_RD: state_in = ST_SCAN;
         ST_SCAN:    if (sid_ff == IDW'(NUM_IDENTITIES)) state_in = ST_CONF_RD;
         ST_CONF_RD: state_in = ST_DECIDE;
         ST_DECIDE:  state_in = ST_OUT;
         ST_OUT:     if (out_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      used_in = used_ff; idx_in = idx_ff; slot_in = slot_ff; sid_in = sid_ff;
      clr_in = clr_ff; best_in = best_ff; sec_in = sec_ff; bid_in = bid_ff;
      cnum_in = cnum_ff; ucnt_in = ucnt_ff; conf_hit_in = conf_hit_ff;
      key_we = 1'b0; key_wa = used_ff[SW-1:0]; key_ra = '0;
      vs_we = 1'b0; vs_wa = '0; vs_wd = '0; vs_ra = '0;
      cm_we = 1'b0; cm_wa = '0; cm_wd = 1'b0;
      uc_we = 1'b0; uc_wd = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            vs_we = 1'b1; cm_we = 1'b1;
            vs_wa = clr_ff[VW-1:0]; cm_wa = clr_ff[VW-1:0];
            clr_in = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            idx_in = '0; cnum_in = '0;
         end
         ST_SEARCH: begin
            key_ra = '0; idx_in = 1'b1 ? UW'(0) : idx_ff;
         end
         ST_SLOT: begin
            // key_rd holds key of slot idx_ff-1 once idx_ff > 0
            key_ra = idx_ff[SW-1:0];
            if (idx_ff != '0 && key_rd == key_ff) begin
               slot_in = SW'(idx_ff - 1'b1);
            end else if (idx_ff < used_ff) begin
               idx_in = idx_ff + 1'b1;
            end else if (face_ff && used_ff < UW'(MAX_TRACKS)) begin
               slot_in = used_ff[SW-1:0];
               key_we  = 1'b1;
               used_in = used_ff + 1'b1;
            end
         end
         ST_CAND_RD: begin
            vs_ra = vaddr(slot_ff, cur_cid);
            if (!(face_ff && cnum_ff < CW'(NUM_CANDIDATES))) begin
               vs_ra = vaddr(slot_ff, '0);
               sid_in = '0; best_in = '0; sec_in = '0; bid_in = '0;
               ucnt_in = ucnt_valid_rd ? uc_rd : '0;
            end
         end
         ST_CAND_WR: begin
            vs_wa = vaddr(slot_ff, cur_cid);
            vs_wd = ssum[SCORE_W] ? SCORE_MAX : ssum[SCORE_W-1:0];
            vs_we = cid_ok;
            cnum_in = cnum_ff + 1'b1;
         end
         ST_SCAN_RD: begin
            vs_ra = vaddr(slot_ff, '0);
            sid_in = IDW'(1);
            if (ucnt_ff != COUNT_MAX) ucnt_in = ucnt_ff + 1'b1;
            uc_we = 1'b1; uc_wd = (ucnt_ff != COUNT_MAX) ? ucnt_ff + 1'b1 : ucnt_ff;
         end
         ST_SCAN: begin
            // vs_rd is the score of identity sid_ff-1
            vs_ra = vaddr(slot_ff, sid_ff[IW-1:0]);
            if (sid_ff != IDW'(NUM_IDENTITIES)) sid_in = sid_ff + 1'b1;
            if (vs_rd >= best_ff) begin
               sec_in = best_ff; best_in = vs_rd; bid_in = IW'(sid_ff - 1'b1);
            end else if (vs_rd > sec_ff) begin
               sec_in = vs_rd;
            end
            if (sid_ff == IDW'(NUM_IDENTITIES)) sid_in = sid_ff;
         end
         ST_CONF_RD: vs_ra = vaddr(slot_ff, bid_ff);
         ST_DECIDE: begin
            conf_hit_in = cm_rd || confirm;
            cm_wa = vaddr(slot_ff, bid_ff); cm_wd = 1'b1; cm_we = confirm;
         end
         ST_OUT: ;
         default: ;
      endcase
   end

   logic sid_wrap;
   assign sid_wrap = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; used_ff <= '0;
         rv_ff <= 1'b0; uc_valid_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; used_ff <= used_in;
         if (uc_we) uc_valid_ff[slot_ff] <= 1'b1;
         if (out_load) rv_ff <= 1'b1;
         else if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; slot_ff <= slot_in; sid_ff <= sid_in; best_ff <= best_in;
      sec_ff <= sec_in; bid_ff <= bid_in; cnum_ff <= cnum_in; ucnt_ff <= ucnt_in;
      conf_hit_ff <= conf_hit_in;
      if (state_ff == ST_IDLE && !req_stall && req_valid) begin
         key_ff <= req_body_track_id; face_ff <= req_face_found;
         cid_ff[0] <= req_cand0_id; conf_ff[0] <= req_cand0_conf;
         cid_ff[1] <= req_cand1_id; conf_ff[1] <= req_cand1_conf;
         cid_ff[2] <= req_cand2_id; conf_ff[2] <= req_cand2_conf;
         cid_ff[3] <= '0; conf_ff[3] <= '0;
      end
      if (out_load) begin
         oe_ff <= key_ff; tn_ff <= TNUM_W'(slot_ff) + 1'b1;
         ob_ff <= CID_W'(bid_ff); obs_ff <= best_ff; oss_ff <= sec_ff;
         od_ff <= (conf_hit_ff && ucnt_ff >= minupd_ff) ? CID_W'(bid_ff) : '0;
      end
   end

   assign req_stall = (state_ff != ST_IDLE) || sid_wrap;
   assign rsp_valid = rv_ff;
   assign rsp_echo_track_id = oe_ff;
   assign rsp_track_number = tn_ff;
   assign rsp_best_id = ob_ff;
   assign rsp_best_score = obs_ff;
   assign rsp_second_score = oss_ff;
   assign rsp_decided_id = od_ff;

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("accepted while busy");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= UW'(MAX_TRACKS)) else $error("track count overflow");
   a_best_ge: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> (obs_ff >= oss_ff)) else $error("second above best");
   a_out_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff == ST_OUT)) else $error("stray result");
`endif
endmodule

[verif/tivf_vote_checker.sv]
// checker for the track identity vote fuser: predicts each result and compares
`timescale 1ns / 1ps
module tivf_vote_checker
   import tivf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [KEY_W-1:0]    req_body_track_id,
   input  logic                req_face_found,
   input  logic [CID_W-1:0]    req_cand0_id,
   input  logic [CONF_W-1:0]   req_cand0_conf,
   input  logic [CID_W-1:0]    req_cand1_id,
   input  logic [CONF_W-1:0]   req_cand1_conf,
   input  logic [CID_W-1:0]    req_cand2_id,
   input  logic [CONF_W-1:0]   req_cand2_conf,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [KEY_W-1:0]    rsp_echo_track_id,
   input  logic [TNUM_W-1:0]   rsp_track_number,
   input  logic [CID_W-1:0]    rsp_best_id,
   input  logic [SCORE_W-1:0]  rsp_best_score,
   input  logic [SCORE_W-1:0]  rsp_second_score,
   input  logic [CID_W-1:0]    rsp_decided_id,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [7:0]          csr_index,
   input  logic [7:0]          csr_data,
   output int                  fail_count,
   output int                  pending,
   output int                  verdicts_seen
);
   localparam int NT = MAX_TRACKS_DEF;
   localparam int NI = NUM_IDENTITIES_DEF;

   typedef struct packed {
      logic [KEY_W-1:0]   tid;
      logic [TNUM_W-1:0]  tnum;
      logic [CID_W-1:0]   best;
      logic [SCORE_W-1:0] best_sc;
      logic [SCORE_W-1:0] second_sc;
      logic [CID_W-1:0]   decided;
   } verdict_t;

   verdict_t         verdict_q[$];
   logic [KEY_W-1:0] slot_key[NT];
   int               slots_taken;
   logic [SCORE_W-1:0] votes[NT][NI];
   bit               locked[NT][NI];
   logic [CNT_W-1:0] seen_cnt[NT];
   logic [THR_W-1:0] thr_tenths;
   logic [CNT_W-1:0] min_seen;
   int               errors;
   int               checked;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // one observation into the vote table; queues a verdict when one is due
   task automatic fuse_observation(input logic [KEY_W-1:0] tid, input bit face,
                                   input logic [CID_W-1:0] cid[3],
                                   input logic [CONF_W-1:0] conf[3]);
      int slot;
      int unsigned sum;
      logic [SCORE_W-1:0] top, runner;
      int top_id;
      verdict_t v;
      slot = -1;
      top = '0;
      runner = '0;
      top_id = 0;
      if (tid == '0) return;
      for (int i = 0; i < slots_taken; i++)
         if (slot_key[i] == tid && slot < 0) slot = i;
      if (slot < 0) begin
         if (!face || slots_taken >= NT) return;
         slot = slots_taken;
         slot_key[slot] = tid;
         slots_taken++;
      end
      if (face)
         for (int c = 0; c < 3; c++)
            if (cid[c] < NI) begin
               sum = votes[slot][cid[c]] + conf[c];
               votes[slot][cid[c]] = (sum > SCORE_MAX) ? SCORE_MAX : sum[SCORE_W-1:0];
            end
      if (seen_cnt[slot] != COUNT_MAX) seen_cnt[slot]++;
      // ties go to the higher identity
      for (int i = 0; i < NI; i++) begin
         if (votes[slot][i] >= top) begin
            runner = top;
            top = votes[slot][i];
            top_id = i;
         end else if (votes[slot][i] > runner) begin
            runner = votes[slot][i];
         end
      end
      if (top != '0 && (runner == '0 ||
          64'(top) * 64'd10 >= 64'(thr_tenths) * 64'(runner)))
         locked[slot][top_id] = 1'b1;
      v.tid = tid;
      v.tnum = TNUM_W'(slot + 1);
      v.best = CID_W'(top_id);
      v.best_sc = top;
      v.second_sc = runner;
      v.decided = (locked[slot][top_id] && seen_cnt[slot] >= min_seen) ? CID_W'(top_id) : '0;
      verdict_q.insert(verdict_q.size(), v);
   endtask

   always @(posedge clock) begin
      verdict_t want;
      logic [CID_W-1:0] cid[3];
      logic [CONF_W-1:0] conf[3];
      if (reset) begin
         verdict_q.delete();
         slots_taken = 0;
         for (int t = 0; t < NT; t++) begin
            slot_key[t] = '0;
            seen_cnt[t] = '0;
            for (int i = 0; i < NI; i++) begin
               votes[t][i] = '0;
               locked[t][i] = 1'b0;
            end
         end
         thr_tenths = THR_RESET;
         min_seen = MINUPD_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == 8'(CSR_RATIO)) thr_tenths = csr_data[THR_W-1:0];
            else if (csr_index == 8'(CSR_MINUPD)) min_seen = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (verdict_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_echo_track_id, '0);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_echo_track_id !== want.tid)
                  report_mismatch("echo_track_id", rsp_echo_track_id, want.tid);
               if (rsp_track_number !== want.tnum)
                  report_mismatch("track_number", rsp_track_number, want.tnum);
               if (rsp_best_id !== want.best)
                  report_mismatch("best_id", rsp_best_id, want.best);
               if (rsp_best_score !== want.best_sc)
                  report_mismatch("best_score", rsp_best_score, want.best_sc);
               if (rsp_second_score !== want.second_sc)
                  report_mismatch("second_score", rsp_second_score, want.second_sc);
               if (rsp_decided_id !== want.decided)
                  report_mismatch("decided_id", rsp_decided_id, want.decided);
            end
         end
         if (req_valid && !req_stall) begin
            cid = '{req_cand0_id, req_cand1_id, req_cand2_id};
            conf = '{req_cand0_conf, req_cand1_conf, req_cand2_conf};
            fuse_observation(req_body_track_id, req_face_found, cid, conf);
         end
      end
      fail_count <= errors;
      pending <= verdict_q.size();
      verdicts_seen <= checked;
   end

   initial begin
      errors = 0;
      checked = 0;
      fail_count = 0;
      pending = 0;
      verdicts_seen = 0;
   end
endmodule

[verif/tb_track_identity_vote_fuser.sv]
// testbench top for the track identity vote fuser: stimulus, config phases and verdict
`timescale 1ns / 1ps
module tb_track_identity_vote_fuser;
   import tivf_pkg::*;

   // settle pause, longer than the worst case per observation with a full table
   localparam int SETTLE_CYCLES = 100;
   // covers the clearing pass after reset, stall bursts and the settle pause
   localparam int STUCK_LIMIT   = 5000;
   localparam logic [7:0] CSR_BOGUS = 8'd2;
   localparam int SAT_ITEMS     = 300;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [KEY_W-1:0]   req_body_track_id;
   logic               req_face_found;
   logic [CID_W-1:0]   req_cand0_id, req_cand1_id, req_cand2_id;
   logic [CONF_W-1:0]  req_cand0_conf, req_cand1_conf, req_cand2_conf;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [KEY_W-1:0]   rsp_echo_track_id;
   logic [TNUM_W-1:0]  rsp_track_number;
   logic [CID_W-1:0]   rsp_best_id, rsp_decided_id;
   logic [SCORE_W-1:0] rsp_best_score, rsp_second_score;
   logic               csr_valid;
   logic               csr_ready;
   logic [7:0]         csr_index;
   logic [7:0]         csr_data;

   int fail_count, pending, verdicts_seen;
   int stuck_cycles;
   int obs_sent;
   int stall_burst;
   bit quiet;
   logic [KEY_W-1:0] body_pool[16];
   logic [CID_W-1:0] favorite[16];

   track_identity_vote_fuser u_top (.*);

   tivf_vote_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side back-pressure: random bursts, none once quiet
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall <= 1'b0;
         stall_burst = 0;
      end else if (stall_burst > 0) begin
         stall_burst--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_burst = $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog: any transfer on any channel resets the count
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // one observation transfer, with an optional sender gap ahead of it
   task automatic send_obs(input logic [KEY_W-1:0] tid, input bit face,
                           input logic [CID_W-1:0] c0, input logic [CONF_W-1:0] f0,
                           input logic [CID_W-1:0] c1, input logic [CONF_W-1:0] f1,
                           input logic [CID_W-1:0] c2, input logic [CONF_W-1:0] f2);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_body_track_id <= tid;
      req_face_found <= face;
      req_cand0_id <= c0;
      req_cand0_conf <= f0;
      req_cand1_id <= c1;
      req_cand1_conf <= f1;
      req_cand2_id <= c2;
      req_cand2_conf <= f2;
      do @(posedge clock); while (req_stall);
      obs_sent++;
   endtask

   // let every queued verdict drain, then give a no-result item time to finish
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [7:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CID_W-1:0] pick_identity(input int k);
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return favorite[k];
      if (r < 95) return CID_W'($urandom_range(0, NUM_IDENTITIES_DEF - 1));
      // out-of-range identities are ignored by the block
      return CID_W'($urandom_range(NUM_IDENTITIES_DEF, 31));
   endfunction

   // mostly known tracks with a favored identity, plus fresh, zero and no-face noise
   task automatic send_random();
      int k, r;
      logic [KEY_W-1:0] tid;
      bit face;
      k = $urandom_range(0, 15);
      r = $urandom_range(0, 99);
      if (r < 82) tid = body_pool[k];
      else if (r < 94) tid = {$urandom, $urandom};
      else tid = '0;
      face = ($urandom_range(0, 99) < 85);
      send_obs(tid, face,
               pick_identity(k), CONF_W'($urandom_range(0, 1000)),
               pick_identity(k), CONF_W'($urandom_range(0, 1000)),
               pick_identity(k), CONF_W'($urandom_range(0, 1000)));
   endtask

   initial begin
      obs_sent = 0;
      quiet = 1'b0;
      stall_burst = 0;
      stuck_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_body_track_id = '0;
      req_face_found = 1'b0;
      req_cand0_id = '0;
      req_cand0_conf = '0;
      req_cand1_id = '0;
      req_cand1_conf = '0;
      req_cand2_id = '0;
      req_cand2_conf = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      body_pool[0] = '1;
      body_pool[1] = 64'd1;
      for (int k = 2; k < 16; k++) begin
         do body_pool[k] = {$urandom, $urandom}; while (body_pool[k] == '0);
      end
      for (int k = 0; k < 16; k++) favorite[k] = CID_W'($urandom_range(0, 19));
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset register values
      send_obs('0, 1, 5'd19, 10'd1000, 5'd0, 10'd1000, 5'd1, 10'd1000);    // no body
      send_obs('1, 0, 5'd19, 10'd1000, 5'd0, 10'd0, 5'd1, 10'd0);          // unseen, no face
      send_obs('1, 1, 5'd19, 10'd1000, 5'd0, 10'd0, 5'd31, 10'd1000);      // opens a track
      send_obs(64'd1, 1, 5'd0, 10'd0, 5'd16, 10'd0, 5'd15, 10'd0);         // zero-zero pair
      send_obs(64'd1, 1, 5'd7, 10'd500, 5'd9, 10'd500, 5'd3, 10'd0);       // tie at the top
      send_obs('1, 0, 5'd2, 10'd1000, 5'd2, 10'd1000, 5'd2, 10'd1000);     // known, no face
      for (int n = 0; n < 5; n++)
         send_obs('1, 1, 5'd19, 10'd1000, 5'd18, 10'd1, 5'd17, 10'd512);
      send_obs(64'd1, 1, 5'd9, 10'd1, 5'd20, 10'd1000, 5'd30, 10'd1000);   // tie broken
      for (int n = 0; n < 4; n++)
         send_obs(64'd1, 1, 5'd7, 10'd700, 5'd8, 10'd341, 5'd9, 10'd682);

      // sender holds off until every result is back, then the loosest setting
      drain_and_settle();
      write_csr(8'(CSR_RATIO), 8'd10);
      write_csr(8'(CSR_MINUPD), 8'd0);
      repeat (450) send_random();

      // strict setting
      drain_and_settle();
      write_csr(8'(CSR_RATIO), 8'd100);
      write_csr(8'(CSR_MINUPD), 8'd255);
      repeat (450) send_random();
      // table is full by now: fresh ids with a face get dropped
      for (int n = 0; n < 8; n++)
         send_obs({$urandom, $urandom} | 64'd1, 1, 5'd4, 10'd900, 5'd5, 10'd90, 5'd6, 10'd9);

      // ignored index, then a random mid setting
      drain_and_settle();
      write_csr(CSR_BOGUS, 8'd3);
      write_csr(8'(CSR_RATIO), 8'($urandom_range(10, 100)));
      write_csr(8'(CSR_MINUPD), 8'($urandom_range(0, 255)));
      repeat (400) send_random();

      // hammer one track until its update count saturates
      drain_and_settle();
      write_csr(8'(CSR_RATIO), 8'd18);
      write_csr(8'(CSR_MINUPD), 8'd200);
      quiet = 1'b1;
      for (int n = 0; n < SAT_ITEMS; n++)
         send_obs(body_pool[3], 1, 5'd12, 10'd1000, 5'd12, 10'd1000, 5'd12, 10'd1000);
      quiet = 1'b0;
      repeat (100) send_random();

      // closing stretch without any idling
      quiet = 1'b1;
      repeat (150) send_random();
      drain_and_settle();

      $display("run covered %0d observations and %0d checked results", obs_sent, verdicts_seen);
      $display("four register settings, full table drops and update count saturation included");
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

[files.f]
rtl/tivf_pkg.sv
rtl/tivf_ram.sv
rtl/track_identity_vote_fuser.sv
verif/tivf_vote_checker.sv
verif/tb_track_identity_vote_fuser.sv
